// ===== src/hashed_match_or_store_table_assert.svh =====
// assertion macros shared by the table and its remainder unit
// both expect clk and rst_n in scope
`ifndef HASHED_MATCH_OR_STORE_TABLE_ASSERT_SVH
`define HASHED_MATCH_OR_STORE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HMST_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define HMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HMST_ASSERT(lbl, ante, cons, msg)
`define HMST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/hmst_pkg.sv =====
package hmst_pkg;

  localparam int LETTER_W    = 5;
  localparam int NUM_LETTERS = 5;
  localparam int KEY_W       = LETTER_W * NUM_LETTERS;
  localparam int HASH_W      = 25;
  localparam int TAG_W       = 16;
  localparam int CNT_W       = 11;
  localparam int LEN_W       = 3;
  localparam int HASH_BASE   = 29;
  localparam int KEY_LETTERS = 5;
  localparam int CNT_RESET   = 1024;

  localparam int BUCKETS_DEF = 1024;
  localparam int SLOTS_DEF   = 10;

  // longest key actually used
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((KEY_LETTERS < NUM_LETTERS) ? KEY_LETTERS : NUM_LETTERS);

  typedef struct packed {
    logic [LETTER_W-1:0] letter_0;
    logic [LETTER_W-1:0] letter_1;
    logic [LETTER_W-1:0] letter_2;
    logic [LETTER_W-1:0] letter_3;
    logic [LETTER_W-1:0] letter_4;
    logic [LEN_W-1:0]    key_length;
    logic [TAG_W-1:0]    entry_tag;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [TAG_W-1:0] matched_tag;
    logic             dropped;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } slot_entry_t;

endpackage

// ===== src/hmst_rem_unit.sv =====
`include "hashed_match_or_store_table_assert.svh"

// bit-serial restoring remainder, one dividend bit per cycle
module hmst_rem_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hmst_pkg::HASH_W-1:0] dividend,
  input  logic [hmst_pkg::CNT_W-1:0]  divisor,
  output logic                      done,
  output logic [hmst_pkg::CNT_W-1:0]  rem
);
  import hmst_pkg::*;

  localparam int STEP_W = $clog2(HASH_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [HASH_W-1:0]   num_r, num_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[HASH_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(HASH_W - 1);
      num_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so one subtract is enough
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[CNT_W-1:0];
      end
      num_nxt = num_r << 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    num_r <= num_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `HMST_ASSERT(a_rem_below_div, busy_r || done_r, rem_r < div_r, "remainder not below divisor")
  `HMST_ASSERT(a_done_not_busy, done_r, !busy_r, "remainder done while still busy")
  `HMST_ASSERT_NEXT(a_start_busy, start, busy_r && step_r == STEP_W'(HASH_W - 1), "start not taken")

endmodule

// ===== src/hashed_match_or_store_table.sv =====
// match-or-store hash table, one item at a time
// each item is hashed, reduced modulo the bucket count by the bit-serial remainder unit,
//   then its bucket is scanned with at most one slot memory read per slot; a new item is
//   taken only once the previous result is loaded into the output register
// reset: bucket count back to 1024, then a clearing pass over all BUCKETS*SLOTS slots
//   (10240 at defaults) with no input taken; configuration writes are taken throughout
`include "hashed_match_or_store_table_assert.svh"

module hashed_match_or_store_table #(
  parameter int BUCKETS = hmst_pkg::BUCKETS_DEF,
  parameter int SLOTS   = hmst_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hmst_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hmst_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hmst_pkg::CNT_W-1:0] cfg_data
);
  import hmst_pkg::*;

  localparam int DEPTH  = BUCKETS * SLOTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int STEP_W = $clog2(NUM_LETTERS);
  localparam logic [CNT_W-1:0] DIV_CAP =
    (BUCKETS >= (2 ** CNT_W)) ? '1 : CNT_W'(BUCKETS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD, ST_SCAN, ST_UPDATE, ST_RESP
  } state_t;

  typedef logic [NUM_LETTERS-1:0][LETTER_W-1:0] letters_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    eff_div;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    hkey_r, hkey_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [SLOT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic                have_free_r, have_free_nxt;
  logic [ADDR_W-1:0]   free_addr_r, free_addr_nxt;
  logic                hit_r, hit_nxt;
  logic [ADDR_W-1:0]   hit_addr_r, hit_addr_nxt;
  logic [TAG_W-1:0]    hit_tag_r, hit_tag_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [LEN_W-1:0]    len_in;
  letters_t            letters_in;
  letters_t            key_in;
  logic [LETTER_W-1:0] code;
  logic [ADDR_W-1:0]   chk_addr;

  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  slot_entry_t         mem [DEPTH];
  slot_entry_t         rd_data_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  slot_entry_t         mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  hmst_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (hash_r),
    .divisor  (eff_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (count_r == '0) begin
      eff_div = CNT_W'(1);
    end else if (count_r > DIV_CAP) begin
      eff_div = DIV_CAP;
    end else begin
      eff_div = count_r;
    end
  end

  // key length clamp and packing of the letters in use
  always_comb begin
    len_in = in_data.key_length;
    if (len_in == '0) begin
      len_in = LEN_W'(1);
    end else if (len_in > LEN_CAP) begin
      len_in = LEN_CAP;
    end
    letters_in = {in_data.letter_0, in_data.letter_1, in_data.letter_2,
                  in_data.letter_3, in_data.letter_4};
    for (int i = 0; i < NUM_LETTERS; i++) begin
      key_in[NUM_LETTERS-1-i] = (LEN_W'(i) < len_in) ? letters_in[NUM_LETTERS-1-i] : '0;
    end
  end

  assign code     = hkey_r[KEY_W-1 -: LETTER_W];
  assign chk_addr = base_r + ADDR_W'(pend_idx_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    hash_nxt      = hash_r;
    key_nxt       = key_r;
    hkey_nxt      = hkey_r;
    len_nxt       = len_r;
    tag_nxt       = tag_r;
    base_nxt      = base_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    have_free_nxt = have_free_r;
    free_addr_nxt = free_addr_r;
    hit_nxt       = hit_r;
    hit_addr_nxt  = hit_addr_r;
    hit_tag_nxt   = hit_tag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = base_r + ADDR_W'(rd_idx_r);

    if (cfg_valid && cfg_ready) begin
      count_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt       = key_in;
          hkey_nxt      = key_in;
          len_nxt       = len_in;
          tag_nxt       = in_data.entry_tag;
          hash_nxt      = '0;
          step_nxt      = '0;
          rd_idx_nxt    = '0;
          have_free_nxt = 1'b0;
          hit_nxt       = 1'b0;
          state_nxt     = ST_HASH;
        end
      end
      ST_HASH: begin
        // base 29 accumulation, first letter most significant
        if (LEN_W'(step_r) < len_r) begin
          hash_nxt = HASH_W'(hash_r * HASH_W'(HASH_BASE)) + HASH_W'(code);
        end
        hkey_nxt = hkey_r << LETTER_W;
        if (step_r == STEP_W'(NUM_LETTERS - 1)) begin
          state_nxt = ST_MOD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_MOD: begin
        if (step_r == STEP_W'(NUM_LETTERS - 1)) begin
          // first cycle here: hash is final, kick off the remainder
          mod_start = 1'b1;
          step_nxt  = '0;
        end else if (mod_done) begin
          base_nxt  = ADDR_W'(mod_rem * SLOTS);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read one slot a cycle, check the previous read's data
        if (rd_idx_r < SLOT_W'(SLOTS)) begin
          mem_re       = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
        end
        if (pend_r) begin
          if (rd_data_r.valid && rd_data_r.key == key_r) begin
            hit_nxt      = 1'b1;
            hit_addr_nxt = chk_addr;
            hit_tag_nxt  = rd_data_r.tag;
            state_nxt    = ST_UPDATE;
          end else begin
            if (!rd_data_r.valid && !have_free_r) begin
              have_free_nxt = 1'b1;
              free_addr_nxt = chk_addr;
            end
            if (pend_idx_r == SLOT_W'(SLOTS - 1)) begin
              state_nxt = ST_UPDATE;
            end
          end
        end
      end
      ST_UPDATE: begin
        if (hit_r) begin
          mem_we    = 1'b1;
          mem_waddr = hit_addr_r;
          mem_wdata = '{valid: 1'b0, key: key_r, tag: hit_tag_r};
        end else if (have_free_r) begin
          mem_we    = 1'b1;
          mem_waddr = free_addr_r;
          mem_wdata = '{valid: 1'b1, key: key_r, tag: tag_r};
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = hit_r;
          out_data_nxt.matched_tag = hit_r ? hit_tag_r : '0;
          out_data_nxt.dropped     = !hit_r && !have_free_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      count_r     <= CNT_W'(CNT_RESET);
      clr_addr_r  <= '0;
      step_r      <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      have_free_r <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      have_free_r <= have_free_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hash_r      <= hash_nxt;
    key_r       <= key_nxt;
    hkey_r      <= hkey_nxt;
    len_r       <= len_nxt;
    tag_r       <= tag_nxt;
    base_r      <= base_nxt;
    pend_idx_r  <= pend_idx_nxt;
    free_addr_r <= free_addr_nxt;
    hit_addr_r  <= hit_addr_nxt;
    hit_tag_r   <= hit_tag_nxt;
    out_data_r  <= out_data_nxt;
  end

  // slot store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  `HMST_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")
  `HMST_ASSERT(a_found_or_dropped, out_valid_r, !(out_data_r.found && out_data_r.dropped), "found and dropped together")
  `HMST_ASSERT(a_miss_tag_zero, out_valid_r && !out_data_r.found, out_data_r.matched_tag == '0, "tag set on a miss")

endmodule
